// ===== rtl/lpbf_pkg.sv =====
// Package for the LED progress bar fill block.
// Holds the sequencer state type, register indexes, field widths and defaults.
// No dependencies.
`default_nettype none

package lpbf_pkg;

    localparam int PIXELS_DEF   = 16;
    localparam int PROG_W       = 16;
    localparam int COLOR_W      = 24;
    localparam int INDEX_W      = 4;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = 24;
    localparam int OUT_DATA_W   = 32;

    localparam logic [PROG_W-1:0] MAX_PROGRESS_RST = 16'd100;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MAX_PROGRESS = 2'd0,
        REG_FILL_MODE    = 2'd1,
        REG_FORE_COLOR   = 2'd2,
        REG_BACK_COLOR   = 2'd3
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_EDGE,
        ST_PAINT,
        ST_CLEAR
    } lpbf_state_t;

endpackage

`default_nettype wire

// ===== rtl/led_progress_bar_fill_top.sv =====
// LED progress bar fill engine: turns progress values into pixel write transactions.
// Depends on lpbf_pkg for the state type, register indexes and widths.
// Usage:
//   The input stream carries one progress value in tdata and the command in
//   tuser (0 update, 1 restart). The output stream carries one pixel write per
//   transaction: index and color in tdata, tlast on the final write of an input.
//   Registers must be written through cfg_we, cfg_index and cfg_data only while idle; the block does not enforce it.
// Timing:
//   An update that produces writes first runs a restoring divider, one
//   quotient bit per cycle, then works out the new edge in ST_EDGE, then
//   emits one write per cycle while the receiver takes them, at most PIXELS
//   writes. A zero update, or an unchanged one with no fore color write pending,
//   produces no writes; a fixed-bar update that writes nothing still passes through
//   the divider and edge states. A restart emits PIXELS writes from pixel 0 up.
//   One input is worked on at a time; the next input is taken once the last
//   write of the previous one sits in the output register.
// Reset and stall:
//   Reset empties the output register, lights no pixel and loads the register
//   defaults. When the receiver holds tready low, the pending write waits in
//   the output register and the paint and clear states pause until it is taken.
`default_nettype none

module led_progress_bar_fill_top
    import lpbf_pkg::*;
#(
    parameter int PIXELS = PIXELS_DEF
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [PROG_W-1:0]     s_axis_tdata,   // [15:0] progress
    input  wire logic [0:0]            s_axis_tuser,   // [0] command
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0]      m_axis_tdata,   // [3:0] pixel_index, [27:4] pixel_color
    output logic                       m_axis_tlast,   // last_write
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int EW = $clog2(PIXELS + 1);
    localparam int DW = PROG_W + $clog2(PIXELS);
    localparam int CW = $clog2(DW);
    localparam logic [EW-1:0] EDGE_NONE = EW'(PIXELS);
    localparam logic [EW-1:0] EDGE_TOP  = EW'(PIXELS - 1);

    lpbf_state_t state_reg, state_next;

    logic [PROG_W-1:0]  max_progress_reg, max_progress_next;
    logic               fill_mode_reg, fill_mode_next;
    logic [COLOR_W-1:0] fore_color_reg, fore_color_next;
    logic [COLOR_W-1:0] back_color_reg, back_color_next;

    logic [EW-1:0]      fill_edge_reg, fill_edge_next;
    logic [PROG_W-1:0]  last_progress_reg, last_progress_next;
    logic               recolor_reg, recolor_next;

    logic [DW-1:0]      div_reg, div_next;
    logic [PROG_W-1:0]  rem_reg, rem_next;
    logic [EW-1:0]      quo_reg, quo_next;
    logic               ovf_reg, ovf_next;
    logic [CW-1:0]      bit_cnt_reg, bit_cnt_next;

    logic [EW-1:0]      pix_reg, pix_next;
    logic [EW-1:0]      hi_reg, hi_next;
    logic [EW-1:0]      lo_reg, lo_next;
    logic               back_run_reg, back_run_next;
    logic               use_back_reg, use_back_next;

    logic               out_valid_reg, out_valid_next;
    logic [INDEX_W-1:0] out_index_reg, out_index_next;
    logic [COLOR_W-1:0] out_color_reg, out_color_next;
    logic               out_last_reg, out_last_next;

    logic               slot_free;
    logic [PROG_W:0]    trial;
    logic               trial_ge;
    logic [EW-1:0]      count;
    logic [EW-1:0]      top;
    logic [EW-1:0]      edge_raw;
    logic [EW-1:0]      new_edge;
    logic [EW+INDEX_W-1:0] pix_wide;

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {{(OUT_DATA_W - COLOR_W - INDEX_W){1'b0}}, out_color_reg, out_index_reg};
    assign m_axis_tlast  = out_last_reg;

    assign trial    = {rem_reg, div_reg[DW-1]};
    assign trial_ge = (trial >= {1'b0, max_progress_reg});
    assign count    = (ovf_reg || (quo_reg > EDGE_NONE)) ? EDGE_NONE : quo_reg;
    assign top      = fill_mode_reg ? EDGE_TOP : EDGE_NONE;
    assign edge_raw = (top > count) ? (top - count) : '0;
    assign new_edge = (edge_raw > EDGE_TOP) ? EDGE_TOP : edge_raw;
    assign pix_wide = {{INDEX_W{1'b0}}, pix_reg};

    always_comb
    begin
        state_next         = state_reg;
        max_progress_next  = max_progress_reg;
        fill_mode_next     = fill_mode_reg;
        fore_color_next    = fore_color_reg;
        back_color_next    = back_color_reg;
        fill_edge_next     = fill_edge_reg;
        last_progress_next = last_progress_reg;
        recolor_next       = recolor_reg;
        div_next           = div_reg;
        rem_next           = rem_reg;
        quo_next           = quo_reg;
        ovf_next           = ovf_reg;
        bit_cnt_next       = bit_cnt_reg;
        pix_next           = pix_reg;
        hi_next            = hi_reg;
        lo_next            = lo_reg;
        back_run_next      = back_run_reg;
        use_back_next      = use_back_reg;
        out_valid_next     = out_valid_reg;
        out_index_next     = out_index_reg;
        out_color_next     = out_color_reg;
        out_last_next      = out_last_reg;

        if (out_valid_reg && m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end

        if (cfg_we)
        begin
            unique case (cfg_reg_t'(cfg_index))
                REG_MAX_PROGRESS: max_progress_next = cfg_data[PROG_W-1:0];
                REG_FILL_MODE:    fill_mode_next    = cfg_data[0];
                REG_FORE_COLOR:
                begin
                    fore_color_next = cfg_data[COLOR_W-1:0];
                    recolor_next    = 1'b1;
                end
                REG_BACK_COLOR:   back_color_next   = cfg_data[COLOR_W-1:0];
                default: ;
            endcase
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    if (s_axis_tuser[0])
                    begin
                        fill_edge_next     = EDGE_NONE;
                        last_progress_next = '0;
                        pix_next           = '0;
                        hi_next            = EDGE_NONE;
                        back_run_next      = 1'b0;
                        use_back_next      = 1'b1;
                        state_next         = ST_PAINT;
                    end
                    else
                    begin
                        last_progress_next = s_axis_tdata;
                        if ((recolor_reg || (last_progress_reg != s_axis_tdata)) &&
                            (s_axis_tdata != '0))
                        begin
                            div_next     = DW'(s_axis_tdata) * DW'(PIXELS);
                            rem_next     = '0;
                            quo_next     = '0;
                            ovf_next     = 1'b0;
                            bit_cnt_next = CW'(DW - 1);
                            state_next   = ST_DIVIDE;
                        end
                    end
                end
            end
            ST_DIVIDE:
            begin
                div_next = {div_reg[DW-2:0], 1'b0};
                rem_next = trial_ge ? PROG_W'(trial - {1'b0, max_progress_reg})
                                    : trial[PROG_W-1:0];
                quo_next = {quo_reg[EW-2:0], trial_ge};
                ovf_next = ovf_reg | quo_reg[EW-1];
                bit_cnt_next = bit_cnt_reg - 1'b1;
                if (bit_cnt_reg == '0)
                begin
                    state_next = ST_EDGE;
                end
            end
            ST_EDGE:
            begin
                use_back_next = 1'b0;
                pix_next      = new_edge;
                lo_next       = fill_edge_reg;
                state_next    = ST_IDLE;
                if (!fill_mode_reg)
                begin
                    hi_next        = EDGE_NONE;
                    back_run_next  = (new_edge > fill_edge_reg);
                    fill_edge_next = new_edge;
                    recolor_next   = 1'b0;
                    state_next     = ST_PAINT;
                end
                else if (new_edge < fill_edge_reg)
                begin
                    hi_next        = fill_edge_reg;
                    back_run_next  = 1'b0;
                    fill_edge_next = new_edge;
                    recolor_next   = 1'b0;
                    state_next     = ST_PAINT;
                end
                else if (fill_edge_reg < new_edge)
                begin
                    fill_edge_next = EDGE_NONE;
                end
            end
            ST_PAINT:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = pix_wide[INDEX_W-1:0];
                    out_color_next = use_back_reg ? back_color_reg : fore_color_reg;
                    out_last_next  = 1'b0;
                    pix_next       = pix_reg + 1'b1;
                    if ((pix_reg + 1'b1) == hi_reg)
                    begin
                        if (back_run_reg)
                        begin
                            pix_next   = fill_edge_reg - 1'b1;
                            state_next = ST_CLEAR;
                        end
                        else
                        begin
                            out_last_next = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                end
            end
            ST_CLEAR:
            begin
                if (slot_free)
                begin
                    out_valid_next = 1'b1;
                    out_index_next = pix_wide[INDEX_W-1:0];
                    out_color_next = back_color_reg;
                    out_last_next  = 1'b0;
                    pix_next       = pix_reg - 1'b1;
                    if (pix_reg == lo_reg)
                    begin
                        out_last_next = 1'b1;
                        state_next    = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= ST_IDLE;
            max_progress_reg  <= MAX_PROGRESS_RST;
            fill_mode_reg     <= 1'b0;
            fore_color_reg    <= '0;
            back_color_reg    <= '0;
            fill_edge_reg     <= EDGE_NONE;
            last_progress_reg <= '0;
            recolor_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            max_progress_reg  <= max_progress_next;
            fill_mode_reg     <= fill_mode_next;
            fore_color_reg    <= fore_color_next;
            back_color_reg    <= back_color_next;
            fill_edge_reg     <= fill_edge_next;
            last_progress_reg <= last_progress_next;
            recolor_reg       <= recolor_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        div_reg       <= div_next;
        rem_reg       <= rem_next;
        quo_reg       <= quo_next;
        ovf_reg       <= ovf_next;
        bit_cnt_reg   <= bit_cnt_next;
        pix_reg       <= pix_next;
        hi_reg        <= hi_next;
        lo_reg        <= lo_next;
        back_run_reg  <= back_run_next;
        use_back_reg  <= use_back_next;
        out_index_reg <= out_index_next;
        out_color_reg <= out_color_next;
        out_last_reg  <= out_last_next;
    end

endmodule

`default_nettype wire
